### rtl/scc_pkg.sv
// shared types and constants of the sensor compensation block
// used by every module of the block, depends on nothing
`default_nettype none
package scc_pkg;

  // register map, one 64-bit slot per register
  typedef enum logic [2:0] {
    REG_CALIB_TEMP    = 3'd0,
    REG_CALIB_PRESS_A = 3'd1,
    REG_CALIB_PRESS_B = 3'd2,
    REG_CALIB_PRESS_C = 3'd3,
    REG_CALIB_HUM_A   = 3'd4,
    REG_CALIB_HUM_B   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [15:0] h4;
    logic [15:0] h5;
    logic [7:0]  h6;
  } calib_t;

  localparam logic [32:0] P_FINE_OFS  = 33'd128000;
  localparam logic [63:0] P_ADC_FULL  = 64'd1048576;
  localparam logic [63:0] P_SCALE     = 64'd3125;
  localparam logic [31:0] H_FINE_OFS  = 32'd76800;
  localparam logic [31:0] H_RND_X     = 32'd16384;
  localparam logic [31:0] H_ADD_A     = 32'd32768;
  localparam logic [31:0] H_ADD_Y     = 32'd2097152;
  localparam logic [31:0] H_RND_Y     = 32'd8192;
  localparam logic [31:0] H_MAX       = 32'd419430400;

  // pipeline depth: input register is stage 0, output register is LAST_STG
  localparam int LAST_STG = 84;

endpackage
`default_nettype wire

### rtl/scc_regs.sv
// calibration register file on an apb-style port
// depends on scc_pkg
`default_nettype none
module scc_regs
  import scc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output calib_t           calib
);

  logic [47:0] temp_r, pa_r, pb_r, pc_r;
  logic [31:0] ha_r;
  logic [39:0] hb_r;
  reg_idx_t    idx;
  logic        wr;

  assign idx = reg_idx_t'(paddr[5:3]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r <= '0;
      pa_r   <= '0;
      pb_r   <= '0;
      pc_r   <= '0;
      ha_r   <= '0;
      hb_r   <= '0;
    end else if (wr) begin
      case (idx)
        REG_CALIB_TEMP:    temp_r <= pwdata[47:0];
        REG_CALIB_PRESS_A: pa_r   <= pwdata[47:0];
        REG_CALIB_PRESS_B: pb_r   <= pwdata[47:0];
        REG_CALIB_PRESS_C: pc_r   <= pwdata[47:0];
        REG_CALIB_HUM_A:   ha_r   <= pwdata[31:0];
        REG_CALIB_HUM_B:   hb_r   <= pwdata[39:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CALIB_TEMP:    prdata = {16'd0, temp_r};
      REG_CALIB_PRESS_A: prdata = {16'd0, pa_r};
      REG_CALIB_PRESS_B: prdata = {16'd0, pb_r};
      REG_CALIB_PRESS_C: prdata = {16'd0, pc_r};
      REG_CALIB_HUM_A:   prdata = {32'd0, ha_r};
      REG_CALIB_HUM_B:   prdata = {24'd0, hb_r};
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    calib.t1 = temp_r[15:0];
    calib.t2 = temp_r[31:16];
    calib.t3 = temp_r[47:32];
    calib.p1 = pa_r[15:0];
    calib.p2 = pa_r[31:16];
    calib.p3 = pa_r[47:32];
    calib.p4 = pb_r[15:0];
    calib.p5 = pb_r[31:16];
    calib.p6 = pb_r[47:32];
    calib.p7 = pc_r[15:0];
    calib.p8 = pc_r[31:16];
    calib.p9 = pc_r[47:32];
    calib.h1 = ha_r[7:0];
    calib.h2 = ha_r[23:8];
    calib.h3 = ha_r[31:24];
    calib.h4 = hb_r[15:0];
    calib.h5 = hb_r[31:16];
    calib.h6 = hb_r[39:32];
  end

endmodule
`default_nettype wire

### rtl/scc_mul64.sv
// two-stage multiplier, low 64 bits of a 64 by 64 product
// built from one full 32x32 product and two low-half cross products
`default_nettype none
module scc_mul64
  import scc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic [63:0]      p
);

  logic [63:0] lo_r;
  logic [31:0] c1_r, c2_r;
  logic [63:0] lo_nxt;
  logic [31:0] c1_nxt, c2_nxt;

  assign lo_nxt = {32'd0, a[31:0]} * {32'd0, b[31:0]};
  assign c1_nxt = a[31:0] * b[63:32];
  assign c2_nxt = a[63:32] * b[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r <= lo_nxt;
      c1_r <= c1_nxt;
      c2_r <= c2_nxt;
      p    <= lo_r + {c1_r + c2_r, 32'd0};
    end
  end

endmodule
`default_nettype wire

### rtl/scc_div.sv
// pipelined signed 64-bit divider, truncating toward zero
// one quotient bit per stage, with a registered input and a registered output
`default_nettype none
module scc_div
  import scc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  output logic [63:0]      quo
);

  logic        neg0_r;
  logic [63:0] num0_r, den0_r;
  logic [63:0] rem_r [64];
  logic [63:0] qd_r  [64];
  logic [63:0] dv_r  [64];
  logic        neg_r [64];

  always_ff @(posedge clk) begin
    if (en) begin
      neg0_r <= num[63] ^ den[63];
      num0_r <= num[63] ? (~num + 64'd1) : num;
      den0_r <= den[63] ? (~den + 64'd1) : den;
    end
  end

  for (genvar i = 0; i < 64; i++) begin : g_stg
    logic [63:0] rem_in, qd_in, dv_in;
    logic        neg_in;
    logic [64:0] r2;
    logic        ge;
    logic [64:0] diff;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign qd_in  = num0_r;
      assign dv_in  = den0_r;
      assign neg_in = neg0_r;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign qd_in  = qd_r[i-1];
      assign dv_in  = dv_r[i-1];
      assign neg_in = neg_r[i-1];
    end

    assign r2   = {rem_in, qd_in[63]};
    assign diff = r2 - {1'b0, dv_in};
    assign ge   = r2 >= {1'b0, dv_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? diff[63:0] : r2[63:0];
        qd_r[i]  <= {qd_in[62:0], ge};
        dv_r[i]  <= dv_in;
        neg_r[i] <= neg_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= neg_r[63] ? (~qd_r[63] + 64'd1) : qd_r[63];
    end
  end

endmodule
`default_nettype wire

### rtl/scc_dly.sv
// enabled shift line of N registers that carries a value
// depends on scc_pkg
`default_nettype none
module scc_dly
  import scc_pkg::*;
#(
  parameter int W = 32,
  parameter int N = 2
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic [W-1:0]      q
);

  logic [W-1:0] tap_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[N-1];

endmodule
`default_nettype wire

### rtl/sensor_calib_compensation.sv
// top level: temperature, pressure and humidity compensation pipeline
// depends on scc_pkg, scc_regs, scc_mul64, scc_div, scc_dly
//
//  port group  direction  contents
//  in_*        slave      one set of raw readings per request
//  out_*       master     one compensated result per request
//  cfg_*       apb        six calibration registers at 8*i
//
// one request enters per cycle while the output is not stalled; its result leaves from stage LAST_STG.
// the length is set by the 64-stage pressure divider plus the multipliers.
// the whole pipeline advances together and holds while the output waits.
// reset clears the stage valid bits and the calibration registers to zero.
`default_nettype none
module sensor_calib_compensation
  import scc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [55:0]  in_tdata,  // adc_temp, adc_press, adc_hum
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [119:0]      out_tdata, // temperature, fine_temperature, pressure, humidity
  output logic [0:0]        out_tuser, // pressure_invalid
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [5:0]   cfg_paddr,
  input  wire logic [63:0]  cfg_pwdata,
  output logic [63:0]       cfg_prdata,
  output logic              cfg_pready
);

  calib_t cal;
  logic   en;
  logic [LAST_STG:0] vld_r;

  assign cfg_pready = 1'b1;

  scc_regs u_regs (
    .clk, .rst_n,
    .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata), .calib(cal)
  );

  assign en        = !vld_r[LAST_STG] || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[LAST_STG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAST_STG-1:0], in_tvalid};
    end
  end

  // coefficients widened
  logic [31:0] t1w, t2w, t3w, h1w, h2w, h3w, h5w, h6w;
  logic [63:0] p1w, p4w, p7w, p8w, p9w, p3w, p6w;
  logic signed [15:0] p2s, p5s;
  assign t1w = {16'd0, cal.t1};
  assign t2w = {{16{cal.t2[15]}}, cal.t2};
  assign t3w = {{16{cal.t3[15]}}, cal.t3};
  assign h1w = {24'd0, cal.h1};
  assign h2w = {{16{cal.h2[15]}}, cal.h2};
  assign h3w = {24'd0, cal.h3};
  assign h5w = {{16{cal.h5[15]}}, cal.h5};
  assign h6w = {{24{cal.h6[7]}}, cal.h6};
  assign p1w = {48'd0, cal.p1};
  assign p3w = {{48{cal.p3[15]}}, cal.p3};
  assign p4w = {{48{cal.p4[15]}}, cal.p4};
  assign p6w = {{48{cal.p6[15]}}, cal.p6};
  assign p7w = {{48{cal.p7[15]}}, cal.p7};
  assign p8w = {{48{cal.p8[15]}}, cal.p8};
  assign p9w = {{48{cal.p9[15]}}, cal.p9};
  assign p2s = signed'(cal.p2);
  assign p5s = signed'(cal.p5);

  // stage 0: input register
  logic [19:0] at_r, ap_r;
  logic [15:0] ah_r;
  always_ff @(posedge clk) begin
    if (en) begin
      at_r <= in_tdata[19:0];
      ap_r <= in_tdata[39:20];
      ah_r <= in_tdata[55:40];
    end
  end

  // temperature, stages 1..5
  logic [31:0] ta_r, d_r, ma_r, dd_r, a3_r, mb_r, fine_r, temp_r;
  logic [31:0] ta_nxt, d_nxt, dsh, fine5;
  assign ta_nxt = {15'd0, at_r[19:3]} - {t1w[30:0], 1'b0};
  assign d_nxt  = {16'd0, at_r[19:4]} - t1w;
  assign dsh    = 32'($signed(dd_r) >>> 12);
  assign fine5  = {fine_r[29:0], 2'b00} + fine_r + 32'd128;

  always_ff @(posedge clk) begin
    if (en) begin
      ta_r   <= ta_nxt;
      d_r    <= d_nxt;
      ma_r   <= ta_r * t2w;
      dd_r   <= d_r * d_r;
      a3_r   <= 32'($signed(ma_r) >>> 11);
      mb_r   <= dsh * t3w;
      fine_r <= a3_r + 32'($signed(mb_r) >>> 14);
      temp_r <= 32'($signed(fine5) >>> 8);
    end
  end

  // pressure, stage 5: first products of v1
  logic signed [32:0] pv1;
  logic signed [65:0] sq_full;
  logic signed [48:0] v1p5_full, v1p2_full;
  logic [63:0] sq_r, v1p5_r, v1p2_r;
  assign pv1       = signed'({fine_r[31], fine_r} - P_FINE_OFS);
  assign sq_full   = pv1 * pv1;
  assign v1p5_full = pv1 * p5s;
  assign v1p2_full = pv1 * p2s;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r   <= sq_full[63:0];
      v1p5_r <= {{15{v1p5_full[48]}}, v1p5_full};
      v1p2_r <= {{15{v1p2_full[48]}}, v1p2_full};
    end
  end

  logic [63:0] sqp6, sqp3, v1p5_d, v1p2_d;
  scc_mul64 u_mul_p6 (.clk, .en, .a(sq_r), .b(p6w), .p(sqp6));
  scc_mul64 u_mul_p3 (.clk, .en, .a(sq_r), .b(p3w), .p(sqp3));
  scc_dly #(.W(64), .N(2)) u_d_v1p5 (.clk, .en, .d(v1p5_r), .q(v1p5_d));
  scc_dly #(.W(64), .N(2)) u_d_v1p2 (.clk, .en, .d(v1p2_r), .q(v1p2_d));

  // stage 8: divisor base and numerator offset term, then the numerator and the divisor
  logic [63:0] v2_r, u_r, pn_r, dv_r;
  logic [19:0] ap8;
  scc_dly #(.W(20), .N(8)) u_d_ap (.clk, .en, .d(ap_r), .q(ap8));

  logic [63:0] tp1, numr, quo;
  always_ff @(posedge clk) begin
    if (en) begin
      v2_r <= sqp6 + {v1p5_d[46:0], 17'd0} + {p4w[28:0], 35'd0};
      u_r  <= 64'h0000_8000_0000_0000 + 64'($signed(sqp3) >>> 8)
              + {v1p2_d[51:0], 12'd0};
      pn_r <= {(P_ADC_FULL[32:0] - {13'd0, ap8}), 31'd0} - v2_r;
      dv_r <= 64'($signed(tp1) >>> 33);
    end
  end

  scc_mul64 u_mul_p1  (.clk, .en, .a(u_r), .b(p1w), .p(tp1));
  scc_mul64 u_mul_num (.clk, .en, .a(pn_r), .b(P_SCALE), .p(numr));
  scc_div   u_div     (.clk, .en, .num(numr), .den(dv_r), .quo(quo));

  logic inv_d, inv_r;
  scc_dly #(.W(1), .N(72)) u_d_inv (.clk, .en, .d(dv_r == 64'd0), .q(inv_d));

  // stages 78..84: second-order correction
  logic [63:0] ps_r, ps_d, m1, xq, yq, yq_d, q_d, sum_r, psum;
  logic [31:0] press_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ps_r <= 64'($signed(quo) >>> 13);
    end
  end

  scc_mul64 u_mul_p8 (.clk, .en, .a(quo),  .b(p8w),  .p(yq));
  scc_mul64 u_mul_p9 (.clk, .en, .a(ps_r), .b(p9w),  .p(m1));
  scc_dly #(.W(64), .N(2)) u_d_ps (.clk, .en, .d(ps_r), .q(ps_d));
  scc_mul64 u_mul_sq (.clk, .en, .a(m1),   .b(ps_d), .p(xq));
  scc_dly #(.W(64), .N(5)) u_d_q  (.clk, .en, .d(quo), .q(q_d));
  scc_dly #(.W(64), .N(3)) u_d_yq (.clk, .en, .d(yq),  .q(yq_d));

  assign psum = 64'($signed(sum_r) >>> 8) + {p7w[59:0], 4'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r   <= q_d + 64'($signed(xq) >>> 25) + 64'($signed(yq_d) >>> 19);
      inv_r   <= inv_d;
      press_r <= inv_d ? 32'd0 : psum[31:0];
    end
  end

  // humidity, stages 5..15
  logic [15:0] ah5;
  scc_dly #(.W(16), .N(5)) u_d_ah (.clk, .en, .d(ah_r), .q(ah5));

  logic [31:0] hv_r, h5v_r, v6_r, v3_r, hx_r;
  logic [31:0] x1_r, y0_r, a0_r, ym_r, x8_r, y1_r, x9_r, yh_r, x10_r, x11_r, y2_r;
  logic [31:0] xx_r, aa_r, xx13_r, ah1_r, xx14_r;
  logic [16:0] hum_r;
  logic [31:0] x0, ahx, xf, yh_rnd;
  assign x0     = hx_r - h5v_r + H_RND_X;
  assign ahx    = 32'($signed(xx_r) >>> 15);
  assign yh_rnd = yh_r + H_RND_Y;
  assign xf     = xx14_r - 32'($signed(ah1_r) >>> 4);

  always_ff @(posedge clk) begin
    if (en) begin
      hv_r   <= fine_r - H_FINE_OFS;
      h5v_r  <= h5w * hv_r;
      v6_r   <= hv_r * h6w;
      v3_r   <= hv_r * h3w;
      hx_r   <= {2'd0, ah5, 14'd0} - {cal.h4[11:0], 20'd0};
      x1_r   <= 32'($signed(x0) >>> 15);
      y0_r   <= 32'($signed(v6_r) >>> 10);
      a0_r   <= 32'($signed(v3_r) >>> 11) + H_ADD_A;
      ym_r   <= y0_r * a0_r;
      x8_r   <= x1_r;
      y1_r   <= 32'($signed(ym_r) >>> 10) + H_ADD_Y;
      x9_r   <= x8_r;
      yh_r   <= y1_r * h2w;
      x10_r  <= x9_r;
      y2_r   <= 32'($signed(yh_rnd) >>> 14);
      x11_r  <= x10_r;
      xx_r   <= x11_r * y2_r;
      aa_r   <= ahx * ahx;
      xx13_r <= xx_r;
      ah1_r  <= 32'($signed(aa_r) >>> 7) * h1w;
      xx14_r <= xx13_r;
      if (xf[31]) begin
        hum_r <= '0;
      end else if (xf > H_MAX) begin
        hum_r <= H_MAX[28:12];
      end else begin
        hum_r <= xf[28:12];
      end
    end
  end

  logic [31:0] temp_o, fine_o;
  logic [16:0] hum_o;
  scc_dly #(.W(32), .N(79)) u_d_temp (.clk, .en, .d(temp_r), .q(temp_o));
  scc_dly #(.W(32), .N(80)) u_d_fine (.clk, .en, .d(fine_r), .q(fine_o));
  scc_dly #(.W(17), .N(69)) u_d_hum  (.clk, .en, .d(hum_r),  .q(hum_o));

  assign out_tdata = {7'd0, hum_o, press_r, fine_o, temp_o};
  assign out_tuser = inv_r;

endmodule
`default_nettype wire

### rtl/scc_checker.sv
// port-level checks for the sensor compensation block
// bound to sensor_calib_compensation, depends on nothing else
`default_nettype none
module scc_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [119:0] out_tdata,
  input wire logic [0:0]   out_tuser
);

  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[112:96] <= 17'd102400)
    else $error("humidity above clamp");

  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[95:64] == 32'd0)
    else $error("invalid pressure not zero");

  a_take_in: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input blocked while output free");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind sensor_calib_compensation scc_checker u_scc_checker (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tuser
);
`default_nettype wire
